// File: hw/rtl/mcfe_pkg.sv
// shared types and constants for the command frame encoder
package mcfe_pkg;

  localparam int LIM_W  = 31;
  localparam int NUM_W  = 47;
  localparam int CODE_W = 16;
  localparam int ID_W   = 8;
  localparam int IDX_W  = 3;
  localparam int FTYPE_W = 5;

  localparam logic [CODE_W-1:0] HALF_CODE = 16'h7FFF;
  localparam logic [CODE_W-1:0] ZERO_CODE = 16'h0000;

  localparam logic [LIM_W-1:0] POS_LIM_RST = 31'd823550;
  localparam logic [LIM_W-1:0] VEL_LIM_RST = 31'd3276800;
  localparam logic [LIM_W-1:0] TRQ_LIM_RST = 31'd1114112;
  localparam logic [LIM_W-1:0] KP_LIM_RST  = 31'd32768000;
  localparam logic [LIM_W-1:0] KD_LIM_RST  = 31'd327680;

  typedef enum logic [IDX_W-1:0] {
    CFG_POS_LIMIT = 3'd0,
    CFG_VEL_LIMIT = 3'd1,
    CFG_TRQ_LIMIT = 3'd2,
    CFG_KP_LIMIT  = 3'd3,
    CFG_KD_LIMIT  = 3'd4,
    CFG_ZERO_OFS  = 3'd5,
    CFG_REVERSE   = 3'd6,
    CFG_MOTOR_ID  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [LIM_W-1:0] pos_lim;
    logic [LIM_W-1:0] vel_lim;
    logic [LIM_W-1:0] trq_lim;
    logic [LIM_W-1:0] kp_lim;
    logic [LIM_W-1:0] kd_lim;
    logic [ID_W-1:0]  motor_id;
  } cfg_t;

  // numerators waiting for division by their limits
  typedef struct packed {
    logic [NUM_W-1:0] pos_num;
    logic [NUM_W-1:0] vel_num;
    logic [NUM_W-1:0] trq_num;
    logic [NUM_W-1:0] kp_num;
    logic [NUM_W-1:0] kd_num;
  } cmd_t;

endpackage

// File: hw/rtl/mit_command_frame_encoder_top.sv
// impedance command to extended frame encoder, top level
// path from accepted command to frame at the output: front stage, queue,
// divider load, divider steps, output register
// frame rate: set by the five 2-bit-per-cycle dividers while they step; a new command loads as the last frame leaves
// reset: synchronous, clears queue and control state and loads register defaults
module mit_command_frame_encoder_top import mcfe_pkg::*; #(
  parameter int CONTROL_FRAME_TYPE = 1,
  parameter int VALUE_WIDTH = 32,
  localparam int CW = (VALUE_WIDTH > LIM_W) ? VALUE_WIDTH : LIM_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [VALUE_WIDTH-1:0] in_target_position,
  input  logic [VALUE_WIDTH-1:0] in_target_velocity,
  input  logic [VALUE_WIDTH-1:0] in_feedforward_torque,
  input  logic [LIM_W-1:0]       in_stiffness,
  input  logic [LIM_W-1:0]       in_damping,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [28:0]            out_frame_identifier,
  output logic [63:0]            out_frame_payload,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CW-1:0]          cfg_data
);

  cfg_t                   cfg_r, cfg_nxt;
  logic [VALUE_WIDTH-1:0] ofs_r, ofs_nxt;
  logic                   rev_r, rev_nxt;
  logic                   q_push, q_full, q_pop, q_empty;
  cmd_t                   q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    ofs_nxt = ofs_r;
    rev_nxt = rev_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POS_LIMIT: cfg_nxt.pos_lim = cfg_data[LIM_W-1:0];
        CFG_VEL_LIMIT: cfg_nxt.vel_lim = cfg_data[LIM_W-1:0];
        CFG_TRQ_LIMIT: cfg_nxt.trq_lim = cfg_data[LIM_W-1:0];
        CFG_KP_LIMIT:  cfg_nxt.kp_lim  = cfg_data[LIM_W-1:0];
        CFG_KD_LIMIT:  cfg_nxt.kd_lim  = cfg_data[LIM_W-1:0];
        CFG_ZERO_OFS:  ofs_nxt = cfg_data[VALUE_WIDTH-1:0];
        CFG_REVERSE:   rev_nxt = cfg_data[0];
        CFG_MOTOR_ID:  cfg_nxt.motor_id = cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_lim  <= POS_LIM_RST;
      cfg_r.vel_lim  <= VEL_LIM_RST;
      cfg_r.trq_lim  <= TRQ_LIM_RST;
      cfg_r.kp_lim   <= KP_LIM_RST;
      cfg_r.kd_lim   <= KD_LIM_RST;
      cfg_r.motor_id <= '0;
      ofs_r          <= '0;
      rev_r          <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      ofs_r <= ofs_nxt;
      rev_r <= rev_nxt;
    end
  end

  mcfe_front #(.VW(VALUE_WIDTH)) u_front (
    .clk, .rst_n, .in_push, .in_full,
    .in_target_position, .in_target_velocity, .in_feedforward_torque,
    .in_stiffness, .in_damping,
    .cfg(cfg_r), .zero_ofs(ofs_r), .reverse(rev_r),
    .q_push, .q_data(q_wdata), .q_full
  );

  mcfe_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
  );

  mcfe_back #(.CONTROL_FRAME_TYPE(CONTROL_FRAME_TYPE)) u_back (
    .clk, .rst_n, .q_empty, .q_data(q_rdata), .q_pop, .cfg(cfg_r),
    .out_empty, .out_pop, .out_frame_identifier, .out_frame_payload
  );

endmodule

// File: hw/rtl/mcfe_front.sv
// front end: direction, offset, clamping and numerator forming
module mcfe_front import mcfe_pkg::*; #(
  parameter int VW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [VW-1:0]        in_target_position,
  input  logic [VW-1:0]        in_target_velocity,
  input  logic [VW-1:0]        in_feedforward_torque,
  input  logic [LIM_W-1:0]     in_stiffness,
  input  logic [LIM_W-1:0]     in_damping,
  input  cfg_t                 cfg,
  input  logic [VW-1:0]        zero_ofs,
  input  logic                 reverse,
  output logic                 q_push,
  output cmd_t                 q_data,
  input  logic                 q_full
);

  localparam int A = VW + 2;
  localparam int E = (A > 33) ? A : 33;

  logic                    s1_v_r, s1_v_nxt;
  logic signed [E-1:0]     pos_r, vel_r, trq_r;
  logic [LIM_W-1:0]        kp_r, kd_r;
  logic signed [E-1:0]     pos_e, vel_e, trq_e, ofs_e;
  logic                    adv;

  function automatic logic [31:0] shift_val(input logic signed [E-1:0] v,
                                            input logic [LIM_W-1:0] lim);
    logic signed [E-1:0] l;
    logic signed [E-1:0] s;
    l = signed'({{(E-LIM_W){1'b0}}, lim});
    if (v > l) s = l;
    else if (v < -l) s = -l;
    else s = v;
    s = s + l;
    return s[31:0];
  endfunction

  function automatic logic [NUM_W-1:0] gain_num(input logic [LIM_W-1:0] g,
                                                input logic [LIM_W-1:0] lim);
    logic [LIM_W-1:0] c;
    c = (g > lim) ? lim : g;
    return {c, 16'b0} - {16'b0, c};
  endfunction

  always_comb begin
    ofs_e = {{(E-VW){zero_ofs[VW-1]}}, zero_ofs};
    pos_e = {{(E-VW){in_target_position[VW-1]}}, in_target_position};
    vel_e = {{(E-VW){in_target_velocity[VW-1]}}, in_target_velocity};
    trq_e = {{(E-VW){in_feedforward_torque[VW-1]}}, in_feedforward_torque};
    if (reverse) begin
      pos_e = -pos_e;
      vel_e = -vel_e;
      trq_e = -trq_e;
    end
    pos_e = pos_e + ofs_e;
  end

  assign in_full = s1_v_r & q_full;
  assign adv     = ~in_full;
  assign q_push  = s1_v_r & ~q_full;
  assign s1_v_nxt = adv ? in_push : s1_v_r;

  always_comb begin
    logic [31:0] px, vx, tx;
    px = shift_val(pos_r, cfg.pos_lim);
    vx = shift_val(vel_r, cfg.vel_lim);
    tx = shift_val(trq_r, cfg.trq_lim);
    q_data.pos_num = {px, 15'b0} - {15'b0, px};
    q_data.vel_num = {vx, 15'b0} - {15'b0, vx};
    q_data.trq_num = {tx, 15'b0} - {15'b0, tx};
    q_data.kp_num  = gain_num(kp_r, cfg.kp_lim);
    q_data.kd_num  = gain_num(kd_r, cfg.kd_lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_push) begin
      pos_r <= pos_e;
      vel_r <= vel_e;
      trq_r <= trq_e;
      kp_r  <= in_stiffness;
      kd_r  <= in_damping;
    end
  end

endmodule

// File: hw/rtl/mcfe_queue.sv
// two-entry queue between front and back
module mcfe_queue import mcfe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t       mem [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign pop_data = mem[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/mcfe_div.sv
// restoring divider, two quotient bits per cycle while step is high
module mcfe_div import mcfe_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [NUM_W-1:0]  num,
  input  logic [LIM_W-1:0]  lim,
  output logic [CODE_W-1:0] quot
);

  logic [31:0]       rem_r, rem_nxt;
  logic [CODE_W-1:0] low_r, low_nxt;

  always_comb begin
    logic [31:0] t;
    rem_nxt = rem_r;
    low_nxt = low_r;
    for (int k = 0; k < 2; k++) begin
      t = {rem_nxt[30:0], low_nxt[CODE_W-1]};
      if (t >= {1'b0, lim}) begin
        t = t - {1'b0, lim};
        low_nxt = {low_nxt[CODE_W-2:0], 1'b1};
      end else begin
        low_nxt = {low_nxt[CODE_W-2:0], 1'b0};
      end
      rem_nxt = t;
    end
  end

  assign quot = low_r;

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= {1'b0, num[NUM_W-1:CODE_W]};
      low_r <= num[CODE_W-1:0];
    end else if (step) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

endmodule

// File: hw/rtl/mcfe_back.sv
// back end: five dividers, frame assembly and output register
module mcfe_back import mcfe_pkg::*; #(
  parameter int CONTROL_FRAME_TYPE = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cmd_t          q_data,
  output logic          q_pop,
  input  cfg_t          cfg,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [28:0]   out_frame_identifier,
  output logic [63:0]   out_frame_payload
);

  localparam logic [3:0] LAST_STEP = 4'd8;

  logic              busy_r, busy_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              out_v_r, out_v_nxt;
  logic [28:0]       id_r;
  logic [63:0]       pay_r;
  logic              finish, out_free, xfer, load, step;
  logic [CODE_W-1:0] pq, vq, tq, kpq, kdq;
  logic [CODE_W-1:0] pc, vc, tc, kpc, kdc;

  assign finish   = busy_r && (cnt_r == LAST_STEP);
  assign out_free = ~out_v_r | out_pop;
  assign xfer     = finish & out_free;
  assign load     = ~q_empty & (~busy_r | xfer);
  assign step     = busy_r && (cnt_r != LAST_STEP);
  assign q_pop    = load;

  mcfe_div u_pos (.clk, .load, .step, .num(q_data.pos_num), .lim(cfg.pos_lim), .quot(pq));
  mcfe_div u_vel (.clk, .load, .step, .num(q_data.vel_num), .lim(cfg.vel_lim), .quot(vq));
  mcfe_div u_trq (.clk, .load, .step, .num(q_data.trq_num), .lim(cfg.trq_lim), .quot(tq));
  mcfe_div u_kp  (.clk, .load, .step, .num(q_data.kp_num),  .lim(cfg.kp_lim),  .quot(kpq));
  mcfe_div u_kd  (.clk, .load, .step, .num(q_data.kd_num),  .lim(cfg.kd_lim),  .quot(kdq));

  // a zero limit gives the midpoint for signed values and zero for gains
  always_comb begin
    pc  = (cfg.pos_lim == '0) ? HALF_CODE : pq;
    vc  = (cfg.vel_lim == '0) ? HALF_CODE : vq;
    tc  = (cfg.trq_lim == '0) ? HALF_CODE : tq;
    kpc = (cfg.kp_lim == '0) ? ZERO_CODE : kpq;
    kdc = (cfg.kd_lim == '0) ? ZERO_CODE : kdq;
  end

  always_comb begin
    busy_nxt  = load ? 1'b1 : (xfer ? 1'b0 : busy_r);
    cnt_nxt   = load ? 4'd0 : (step ? cnt_r + 4'd1 : cnt_r);
    out_v_nxt = xfer ? 1'b1 : (out_pop ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= 4'd0;
      out_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      id_r  <= {FTYPE_W'(CONTROL_FRAME_TYPE), tc, cfg.motor_id};
      pay_r <= {pc, vc, kpc, kdc};
    end
  end

  assign out_empty            = ~out_v_r;
  assign out_frame_identifier = id_r;
  assign out_frame_payload    = pay_r;

endmodule
